// ===== rtl/sts_pkg.sv =====
// Shared types and constants of the script token scanner.
// Used by sts_scan_step and script_token_scanner; depends on nothing.
package sts_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LENGTH_BITS = 16;
	localparam int LINE_BITS   = 16;
	localparam int KIND_BITS   = 6;
	localparam int RES_MAX     = 3;

	localparam int OUT_BITS  = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
	localparam int OUT_TDATA = OUT_BYTES * 8;

	typedef enum logic [KIND_BITS-1:0] {
		K_VAR, K_LOOP, K_QUESTION, K_SEMI, K_LBRACE, K_RBRACE, K_LPAREN, K_RPAREN,
		K_RSQUARE, K_DOT, K_COMMA, K_PIPE, K_AND, K_CARET, K_PLUS, K_STAR,
		K_PERCENT, K_NULL, K_EQ, K_EQEQ, K_BANG, K_BANGEQ, K_COLON, K_TRUE,
		K_FALSE, K_LESS, K_LESSEQ, K_RETURN, K_READ, K_READBOOL, K_READNUM,
		K_SLASH, K_UPTRI, K_BSLASH, K_DOWNTRI, K_MINUS, K_ARROW, K_GREATER,
		K_GREATEREQ, K_GT2, K_GT3, K_LSQUARE, K_TABLE, K_IDENT, K_INT, K_FLOAT,
		K_STRING, K_ERR_STR, K_ERR_CHAR, K_EOF
	} kind_t;

	typedef enum logic [4:0] {
		M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUM, M_NUMDOT, M_FLOAT, M_STRING,
		M_BANG, M_EQ, M_BSLASH, M_MINUS, M_COLON, M_LESS, M_GT, M_GT2,
		M_LSQ, M_LSQHASH
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic [OFFSET_BITS-1:0] pos;
		logic [OFFSET_BITS-1:0] start;
		logic [LENGTH_BITS-1:0] count;
		logic [LINE_BITS-1:0]   line;
	} scan_state_t;

	typedef struct packed {
		kind_t                  kind;
		logic [OFFSET_BITS-1:0] offset;
		logic [LENGTH_BITS-1:0] length;
		logic [LINE_BITS-1:0]   line;
	} result_t;

endpackage

// ===== rtl/script_token_scanner.sv =====
// Script token scanner top level: byte stream in, token stream out.
// Depends on sts_pkg and sts_scan_step.
// A token is offered on the output in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle while the output accepts; a byte that closes k tokens
// (k up to 3) stalls the input while the buffer drains, one beat a cycle while m_tready is high.
// Reset (arst_n low): no token pending, offset 0, line 1, result buffer empty.
// A zero byte emits EOF and returns the scanner to no token pending, offset 0, line 1.
module script_token_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // text_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sts_pkg::OUT_TDATA-1:0] m_tdata,  // token_kind, start_offset, token_length, line_number, pad
	output logic                          m_tlast   // last_of_run
);

	localparam int PAD_BITS = sts_pkg::OUT_TDATA - sts_pkg::OUT_BITS;

	sts_pkg::scan_state_t state_q, state_next;
	sts_pkg::result_t     step_res [sts_pkg::RES_MAX];
	sts_pkg::result_t     res_s1   [sts_pkg::RES_MAX];
	sts_pkg::result_t     out_res;
	logic [1:0]           step_count, rem_q, idx_q;
	logic                 step_end, accept, pop;

	sts_scan_step u_step (
		.text_byte (s_tdata),
		.cur       (state_q),
		.nxt       (state_next),
		.res       (step_res),
		.res_count (step_count),
		.ended     (step_end)
	);

	assign m_tvalid = rem_q != 2'd0;
	assign m_tlast  = rem_q == 2'd1;
	assign pop      = m_tvalid && m_tready;
	assign s_tready = (rem_q == 2'd0) || (rem_q == 2'd1 && m_tready);
	assign accept   = s_tvalid && s_tready;
	assign out_res  = res_s1[idx_q];
	assign m_tdata  = {PAD_BITS'(0), out_res.line, out_res.length, out_res.offset,
		out_res.kind};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: sts_pkg::M_IDLE, pos: '0, start: '0, count: '0,
				line: sts_pkg::LINE_BITS'(1)};
			rem_q   <= 2'd0;
			idx_q   <= 2'd0;
		end else if (accept) begin
			state_q <= state_next;
			rem_q   <= step_count;
			idx_q   <= 2'd0;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= step_res;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == 2'd2 || rem_q == 2'd3) |-> !s_tready)
		else $error("input taken while results still queued");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, idx_q} + {1'b0, rem_q} <= 3'd3))
		else $error("result buffer index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tdata == 8'd0) |=>
		(state_q.pos == '0 && state_q.line == sts_pkg::LINE_BITS'(1) &&
		state_q.mode == sts_pkg::M_IDLE && m_tvalid))
		else $error("end of text did not restart scanner");

endmodule

// ===== rtl/sts_scan_step.sv =====
// Next-state and token logic for one source byte: up to three results per beat.
// Depends on sts_pkg.
module sts_scan_step (
	input  logic [7:0]           text_byte,
	input  sts_pkg::scan_state_t cur,
	output sts_pkg::scan_state_t nxt,
	output sts_pkg::result_t     res [sts_pkg::RES_MAX],
	output logic [1:0]           res_count,
	output logic                 ended
);

	localparam int LB = sts_pkg::LENGTH_BITS;

	function automatic logic [LB-1:0] sat_add(input logic [LB-1:0] a, input logic [1:0] d);
		logic [LB:0] sum;
		sum = {1'b0, a} + (LB+1)'(d);
		return sum[LB] ? {LB{1'b1}} : sum[LB-1:0];
	endfunction

	logic alpha_byte, digit_byte, is_alnum;
	assign alpha_byte = (text_byte >= "a" && text_byte <= "z") ||
		(text_byte >= "A" && text_byte <= "Z") || text_byte == "_";
	assign digit_byte = text_byte >= "0" && text_byte <= "9";
	assign is_alnum   = alpha_byte || digit_byte;

	// scan of a byte with no token pending
	logic                f_emit, f_begin, f_nl, f_end;
	sts_pkg::kind_t      f_kind;
	sts_pkg::mode_t      f_mode;
	logic [LB-1:0]       f_len;

	always_comb begin
		f_emit  = 1'b0;
		f_begin = 1'b0;
		f_nl    = 1'b0;
		f_end   = 1'b0;
		f_kind  = sts_pkg::K_ERR_CHAR;
		f_mode  = sts_pkg::M_IDLE;
		f_len   = LB'(1);
		if (text_byte == 8'd0) begin
			f_emit = 1'b1;
			f_kind = sts_pkg::K_EOF;
			f_len  = '0;
			f_end  = 1'b1;
		end else if (text_byte == " " || text_byte == "\t" || text_byte == 8'h0D) begin
			f_emit = 1'b0;
		end else if (text_byte == "\n") begin
			f_nl = 1'b1;
		end else if (alpha_byte) begin
			f_begin = 1'b1;
			f_mode  = sts_pkg::M_IDENT;
		end else if (digit_byte) begin
			f_begin = 1'b1;
			f_mode  = sts_pkg::M_NUM;
		end else begin
			f_emit = 1'b1;
			case (text_byte)
				"$": f_kind = sts_pkg::K_VAR;
				"@": f_kind = sts_pkg::K_LOOP;
				"?": f_kind = sts_pkg::K_QUESTION;
				";": f_kind = sts_pkg::K_SEMI;
				"{": f_kind = sts_pkg::K_LBRACE;
				"}": f_kind = sts_pkg::K_RBRACE;
				"(": f_kind = sts_pkg::K_LPAREN;
				")": f_kind = sts_pkg::K_RPAREN;
				"]": f_kind = sts_pkg::K_RSQUARE;
				".": f_kind = sts_pkg::K_DOT;
				",": f_kind = sts_pkg::K_COMMA;
				"|": f_kind = sts_pkg::K_PIPE;
				"&": f_kind = sts_pkg::K_AND;
				"^": f_kind = sts_pkg::K_CARET;
				"+": f_kind = sts_pkg::K_PLUS;
				"*": f_kind = sts_pkg::K_STAR;
				"%": f_kind = sts_pkg::K_PERCENT;
				"#": f_kind = sts_pkg::K_NULL;
				"/": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_SLASH; end
				"!": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_BANG; end
				"=": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_EQ; end
				"\\": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_BSLASH; end
				"-": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_MINUS; end
				":": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_COLON; end
				"<": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_LESS; end
				">": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_GT; end
				"[": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_LSQ; end
				"\"": begin f_emit = 1'b0; f_begin = 1'b1; f_mode = sts_pkg::M_STRING; end
				default: f_kind = sts_pkg::K_ERR_CHAR;
			endcase
		end
	end

	// pending-token close: slot 0 = pending token, slot 1 = split-off dot or hash
	logic           e0_v, e1_v, do_fresh, nl;
	sts_pkg::kind_t e0_kind, e1_kind;
	logic [LB-1:0]  e0_len;
	sts_pkg::mode_t m_next;
	logic [LB-1:0]  cnt_next;
	logic [sts_pkg::OFFSET_BITS-1:0] prev_pos;
	sts_pkg::result_t r0, r1, rf;

	assign prev_pos = cur.pos - sts_pkg::OFFSET_BITS'(1);

	always_comb begin
		e0_v     = 1'b0;
		e1_v     = 1'b0;
		do_fresh = 1'b0;
		nl       = 1'b0;
		e0_kind  = sts_pkg::K_ERR_CHAR;
		e1_kind  = sts_pkg::K_DOT;
		e0_len   = LB'(1);
		m_next   = cur.mode;
		cnt_next = cur.count;
		unique case (cur.mode)
			sts_pkg::M_SLASH: begin
				if (text_byte == "/") begin
					m_next = sts_pkg::M_COMMENT;
				end else if (text_byte == "\\") begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_UPTRI; e0_len = LB'(2);
					m_next = sts_pkg::M_IDLE;
				end else begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_SLASH; do_fresh = 1'b1;
				end
			end
			sts_pkg::M_COMMENT: begin
				if (text_byte == "\n") begin
					nl = 1'b1; m_next = sts_pkg::M_IDLE;
				end else if (text_byte == 8'd0) begin
					do_fresh = 1'b1;
				end
			end
			sts_pkg::M_IDENT: begin
				if (is_alnum) begin
					cnt_next = sat_add(cur.count, 2'd1);
				end else begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_IDENT; e0_len = cur.count;
					do_fresh = 1'b1;
				end
			end
			sts_pkg::M_NUM: begin
				if (digit_byte) begin
					cnt_next = sat_add(cur.count, 2'd1);
				end else if (text_byte == ".") begin
					m_next = sts_pkg::M_NUMDOT;
				end else begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_INT; e0_len = cur.count;
					do_fresh = 1'b1;
				end
			end
			sts_pkg::M_NUMDOT: begin
				if (digit_byte) begin
					cnt_next = sat_add(cur.count, 2'd2);
					m_next   = sts_pkg::M_FLOAT;
				end else begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_INT; e0_len = cur.count;
					e1_v = 1'b1; e1_kind = sts_pkg::K_DOT;
					do_fresh = 1'b1;
				end
			end
			sts_pkg::M_FLOAT: begin
				if (digit_byte) begin
					cnt_next = sat_add(cur.count, 2'd1);
				end else begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_FLOAT; e0_len = cur.count;
					do_fresh = 1'b1;
				end
			end
			sts_pkg::M_STRING: begin
				if (text_byte == 8'd0) begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_ERR_STR; e0_len = cur.count;
					do_fresh = 1'b1;
				end else begin
					cnt_next = sat_add(cur.count, 2'd1);
					if (text_byte == "\"") begin
						e0_v = 1'b1; e0_kind = sts_pkg::K_STRING; e0_len = cnt_next;
						m_next = sts_pkg::M_IDLE;
					end else if (text_byte == "\n") begin
						nl = 1'b1;
					end
				end
			end
			sts_pkg::M_BANG, sts_pkg::M_EQ: begin
				e0_v = 1'b1;
				if (text_byte == "=") begin
					e0_kind = (cur.mode == sts_pkg::M_BANG) ? sts_pkg::K_BANGEQ : sts_pkg::K_EQEQ;
					e0_len  = LB'(2);
					m_next  = sts_pkg::M_IDLE;
				end else begin
					e0_kind  = (cur.mode == sts_pkg::M_BANG) ? sts_pkg::K_BANG : sts_pkg::K_EQ;
					do_fresh = 1'b1;
				end
			end
			sts_pkg::M_BSLASH: begin
				e0_v = 1'b1;
				if (text_byte == "/") begin
					e0_kind = sts_pkg::K_DOWNTRI; e0_len = LB'(2); m_next = sts_pkg::M_IDLE;
				end else begin
					e0_kind = sts_pkg::K_BSLASH; do_fresh = 1'b1;
				end
			end
			sts_pkg::M_MINUS: begin
				e0_v = 1'b1;
				if (text_byte == ">") begin
					e0_kind = sts_pkg::K_ARROW; e0_len = LB'(2); m_next = sts_pkg::M_IDLE;
				end else begin
					e0_kind = sts_pkg::K_MINUS; do_fresh = 1'b1;
				end
			end
			sts_pkg::M_COLON: begin
				e0_v = 1'b1;
				if (text_byte == ")") begin
					e0_kind = sts_pkg::K_TRUE; e0_len = LB'(2); m_next = sts_pkg::M_IDLE;
				end else if (text_byte == "(") begin
					e0_kind = sts_pkg::K_FALSE; e0_len = LB'(2); m_next = sts_pkg::M_IDLE;
				end else begin
					e0_kind = sts_pkg::K_COLON; do_fresh = 1'b1;
				end
			end
			sts_pkg::M_LESS: begin
				e0_v   = 1'b1;
				e0_len = LB'(2);
				m_next = sts_pkg::M_IDLE;
				case (text_byte)
					"=": e0_kind = sts_pkg::K_LESSEQ;
					"~": e0_kind = sts_pkg::K_RETURN;
					"<": e0_kind = sts_pkg::K_READ;
					"?": e0_kind = sts_pkg::K_READBOOL;
					"#": e0_kind = sts_pkg::K_READNUM;
					default: begin
						e0_kind  = sts_pkg::K_LESS;
						e0_len   = LB'(1);
						m_next   = cur.mode;
						do_fresh = 1'b1;
					end
				endcase
			end
			sts_pkg::M_GT: begin
				if (text_byte == ">") begin
					m_next = sts_pkg::M_GT2;
				end else if (text_byte == "=") begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_GREATEREQ; e0_len = LB'(2);
					m_next = sts_pkg::M_IDLE;
				end else begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_GREATER; do_fresh = 1'b1;
				end
			end
			sts_pkg::M_GT2: begin
				e0_v = 1'b1;
				if (text_byte == ">") begin
					e0_kind = sts_pkg::K_GT3; e0_len = LB'(3); m_next = sts_pkg::M_IDLE;
				end else begin
					e0_kind = sts_pkg::K_GT2; e0_len = LB'(2); do_fresh = 1'b1;
				end
			end
			sts_pkg::M_LSQ: begin
				if (text_byte == "#") begin
					m_next = sts_pkg::M_LSQHASH;
				end else begin
					e0_v = 1'b1; e0_kind = sts_pkg::K_LSQUARE; do_fresh = 1'b1;
				end
			end
			sts_pkg::M_LSQHASH: begin
				e0_v = 1'b1;
				if (text_byte == "]") begin
					e0_kind = sts_pkg::K_TABLE; e0_len = LB'(3); m_next = sts_pkg::M_IDLE;
				end else begin
					e0_kind = sts_pkg::K_LSQUARE;
					e1_v = 1'b1; e1_kind = sts_pkg::K_NULL;
					do_fresh = 1'b1;
				end
			end
			default: do_fresh = 1'b1;
		endcase
	end

	logic ef_v, nl_all;

	assign ef_v   = do_fresh && f_emit;
	assign nl_all = nl || (do_fresh && f_nl);
	assign ended  = do_fresh && f_end;

	always_comb begin
		r0 = '{kind: e0_kind, offset: cur.start, length: e0_len, line: cur.line};
		r1 = '{kind: e1_kind, offset: prev_pos, length: LB'(1), line: cur.line};
		rf = '{kind: f_kind, offset: cur.pos, length: f_len, line: cur.line};
		res[0] = e0_v ? r0 : rf;
		res[1] = e1_v ? r1 : rf;
		res[2] = rf;
		res_count = 2'(e0_v) + 2'(e1_v) + 2'(ef_v);
	end

	always_comb begin
		if (ended) begin
			nxt = '{mode: sts_pkg::M_IDLE, pos: '0, start: '0, count: '0,
				line: sts_pkg::LINE_BITS'(1)};
		end else begin
			nxt.mode  = do_fresh ? f_mode : m_next;
			nxt.pos   = cur.pos + sts_pkg::OFFSET_BITS'(1);
			nxt.start = (do_fresh && f_begin) ? cur.pos : cur.start;
			nxt.count = (do_fresh && f_begin) ? LB'(1) : cnt_next;
			nxt.line  = (nl_all && !(&cur.line)) ? cur.line + sts_pkg::LINE_BITS'(1) : cur.line;
		end
	end

endmodule
